// ===== design/cpba_pkg.sv =====
// ----------------------------------------------------------------------------
// cpba_pkg
// Shared sizes, codes and controller/datapath interface types for the
// contiguous page bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpba_pkg;

    localparam int MAP_PAGES = 512;
    localparam int WORD_BITS = 8;
    localparam int MAP_WORDS = MAP_PAGES / WORD_BITS;
    localparam int PAGE_W    = $clog2(MAP_PAGES);
    localparam int WIDX_W    = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int RUN_W     = $clog2(MAP_PAGES + 1);

    localparam int ADDR_W    = 48;
    localparam int BYTES_W   = 32;
    localparam int PSL_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [PSL_W-1:0] PSL_RESET = PSL_W'(21);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE_LOG2 = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        RES_OK      = 2'd0,
        RES_NOSPACE = 2'd1,
        RES_RANGE   = 2'd2
    } result_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SCAN,
        S_ADDR,
        S_UPD_START,
        S_UPD,
        S_RESP
    } state_t;

    typedef struct packed {
        logic           load;
        logic           decode;
        logic           scan_start;
        logic           scan_step;
        logic           alloc_addr;
        logic           free_setup;
        logic           upd_start;
        logic           upd_step;
        logic           res_wr;
        result_status_t res_code;
        logic           out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic func_free;
        logic zero_size;
        logic alloc_too_big;
        logic free_bad;
        logic scan_hit;
        logic scan_last;
        logic upd_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/cpba_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpba_ctrl
// Request sequencer: decode, range check, first-fit scan, map update and
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cpba_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cpba_pkg::dp_stat_t stat,
    output cpba_pkg::dp_cmd_t       cmd
);

    cpba_pkg::state_t state_reg;
    cpba_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cpba_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.res_code = cpba_pkg::RES_OK;
        s_ready      = 1'b0;
        case (state_reg)
            cpba_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = cpba_pkg::S_DECODE;
                end
            end
            cpba_pkg::S_DECODE: begin
                cmd.decode = 1'b1;
                state_next = cpba_pkg::S_CHECK;
            end
            cpba_pkg::S_CHECK: begin
                if (stat.zero_size ||
                    (!stat.func_free && stat.alloc_too_big) ||
                    (stat.func_free && stat.free_bad)) begin
                    cmd.res_wr   = 1'b1;
                    cmd.res_code = cpba_pkg::RES_RANGE;
                    state_next   = cpba_pkg::S_RESP;
                end else if (!stat.func_free) begin
                    cmd.scan_start = 1'b1;
                    state_next     = cpba_pkg::S_SCAN;
                end else begin
                    cmd.free_setup = 1'b1;
                    state_next     = cpba_pkg::S_UPD_START;
                end
            end
            cpba_pkg::S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit) begin
                    state_next = cpba_pkg::S_ADDR;
                end else if (stat.scan_last) begin
                    cmd.res_wr   = 1'b1;
                    cmd.res_code = cpba_pkg::RES_NOSPACE;
                    state_next   = cpba_pkg::S_RESP;
                end
            end
            cpba_pkg::S_ADDR: begin
                cmd.alloc_addr = 1'b1;
                state_next     = cpba_pkg::S_UPD_START;
            end
            cpba_pkg::S_UPD_START: begin
                cmd.upd_start = 1'b1;
                state_next    = cpba_pkg::S_UPD;
            end
            cpba_pkg::S_UPD: begin
                cmd.upd_step = 1'b1;
                if (stat.upd_last) begin
                    cmd.res_wr   = 1'b1;
                    cmd.res_code = cpba_pkg::RES_OK;
                    state_next   = cpba_pkg::S_RESP;
                end
            end
            cpba_pkg::S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = cpba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cpba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/cpba_datapath.sv =====
// ----------------------------------------------------------------------------
// cpba_datapath
// Configuration registers, request registers, page map memory with per-word
// valid bits, run scanner, range marker and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpba_datapath (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [cpba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cpba_pkg::ADDR_W-1:0]        cfg_wr_data,
    input  wire logic                               s_func,
    input  wire logic [cpba_pkg::BYTES_W-1:0]       s_byte_count,
    input  wire logic [cpba_pkg::ADDR_W-1:0]        s_virtual_address,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [cpba_pkg::ADDR_W-1:0]             m_address,
    output logic [1:0]                              m_status,
    input  wire cpba_pkg::dp_cmd_t                  cmd,
    output cpba_pkg::dp_stat_t                      stat
);

    localparam int AW  = cpba_pkg::ADDR_W;
    localparam int BW  = cpba_pkg::BYTES_W;
    localparam int PW  = cpba_pkg::PAGE_W;
    localparam int IW  = cpba_pkg::WIDX_W;
    localparam int TW  = cpba_pkg::BIT_W;
    localparam int RW  = cpba_pkg::RUN_W;
    localparam int WB  = cpba_pkg::WORD_BITS;
    localparam int SW  = cpba_pkg::PSL_W;

    logic [AW-1:0]  base_address_reg;
    logic [SW-1:0]  page_size_log2_reg;

    logic           func_reg;
    logic [BW-1:0]  bytes_reg;
    logic [AW-1:0]  va_reg;
    logic [BW-1:0]  n_reg;
    logic [AW:0]    diff_reg;

    logic [IW-1:0]  word_reg;
    logic [RW-1:0]  run_reg;
    logic [PW-1:0]  end_reg;
    logic [PW-1:0]  lo_reg;
    logic [PW-1:0]  hi_reg;
    logic           set_reg;

    logic [AW-1:0]                   res_addr_reg;
    cpba_pkg::result_status_t        res_status_reg;
    logic                            m_valid_reg;
    logic [AW-1:0]                   m_address_reg;
    logic [1:0]                      m_status_reg;

    logic [WB-1:0]        map_mem [cpba_pkg::MAP_WORDS];
    logic [cpba_pkg::MAP_WORDS-1:0] map_vld_reg;
    logic [WB-1:0]        rd_data_reg;
    logic                 rd_vld_reg;

    logic [BW:0]    size_m1;
    logic [BW:0]    bytes_sum;
    logic [AW-1:0]  start_full;
    logic [BW:0]    free_end;
    logic [WB-1:0]  rd_word;
    logic [RW-1:0]  run_next;
    logic           hit;
    logic [PW-1:0]  hit_page;
    logic [WB-1:0]  upd_mask;
    logic [WB-1:0]  wr_word;
    logic [PW-1:0]  alloc_start;
    logic           mem_re;
    logic [IW-1:0]  mem_ra;
    logic           mem_we;
    logic [IW-1:0]  lo_word;
    logic [IW-1:0]  hi_word;

    assign lo_word = lo_reg[PW-1:TW];
    assign hi_word = hi_reg[PW-1:TW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_address_reg   <= '0;
            page_size_log2_reg <= cpba_pkg::PSL_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == cpba_pkg::CFG_BASE_ADDRESS) begin
                base_address_reg <= cfg_wr_data;
            end else if (cfg_index == cpba_pkg::CFG_PAGE_SIZE_LOG2) begin
                page_size_log2_reg <= cfg_wr_data[SW-1:0];
            end
        end
    end

    assign size_m1    = (BW+1)'(((BW+1)'(1) << page_size_log2_reg) - (BW+1)'(1));
    assign bytes_sum  = {1'b0, bytes_reg} + size_m1;
    assign start_full = diff_reg[AW-1:0] >> page_size_log2_reg;
    assign free_end   = (BW+1)'(n_reg) + (BW+1)'(start_full[RW-1:0]);
    assign rd_word    = rd_vld_reg ? rd_data_reg : '0;
    assign alloc_start = PW'(RW'(end_reg) + RW'(1) - RW'(n_reg));

    always_comb begin
        run_next = run_reg;
        hit      = 1'b0;
        hit_page = '0;
        for (int b = 0; b < WB; b++) begin
            if (!hit) begin
                if (rd_word[b]) begin
                    run_next = '0;
                end else begin
                    run_next = RW'(run_next + 1'b1);
                end
                if (run_next == RW'(n_reg)) begin
                    hit      = 1'b1;
                    hit_page = {word_reg, TW'(b)};
                end
            end
        end
    end

    always_comb begin
        for (int b = 0; b < WB; b++) begin
            upd_mask[b] = ({word_reg, TW'(b)} >= lo_reg) && ({word_reg, TW'(b)} <= hi_reg);
        end
        wr_word = set_reg ? (rd_word | upd_mask) : (rd_word & ~upd_mask);
    end

    always_comb begin
        mem_re = 1'b0;
        mem_ra = '0;
        if (cmd.scan_start) begin
            mem_re = 1'b1;
        end else if (cmd.upd_start) begin
            mem_re = 1'b1;
            mem_ra = lo_word;
        end else if (cmd.scan_step || cmd.upd_step) begin
            mem_re = 1'b1;
            mem_ra = IW'(word_reg + 1'b1);
        end
    end

    assign mem_we = cmd.upd_step;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[word_reg] <= wr_word;
        end
        if (mem_re) begin
            rd_data_reg <= map_mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (mem_we) begin
                map_vld_reg[word_reg] <= 1'b1;
            end
            if (mem_re) begin
                rd_vld_reg <= map_vld_reg[mem_ra];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg     <= s_func;
            bytes_reg    <= s_byte_count;
            va_reg       <= s_virtual_address;
            res_addr_reg <= '1;
        end
        if (cmd.decode) begin
            n_reg    <= BW'(bytes_sum >> page_size_log2_reg);
            diff_reg <= {1'b0, va_reg} - {1'b0, base_address_reg};
        end
        if (cmd.scan_start) begin
            word_reg <= '0;
            run_reg  <= '0;
        end
        if (cmd.scan_step) begin
            word_reg <= IW'(word_reg + 1'b1);
            run_reg  <= run_next;
            if (hit) begin
                end_reg <= hit_page;
            end
        end
        if (cmd.alloc_addr) begin
            lo_reg       <= alloc_start;
            hi_reg       <= end_reg;
            set_reg      <= 1'b1;
            res_addr_reg <= base_address_reg + (AW'(alloc_start) << page_size_log2_reg);
        end
        if (cmd.free_setup) begin
            lo_reg  <= start_full[PW-1:0];
            hi_reg  <= PW'(free_end - 1'b1);
            set_reg <= 1'b0;
        end
        if (cmd.upd_start) begin
            word_reg <= lo_word;
        end
        if (cmd.upd_step) begin
            word_reg <= IW'(word_reg + 1'b1);
        end
        if (cmd.res_wr) begin
            res_status_reg <= cmd.res_code;
        end
        if (cmd.out_load) begin
            m_address_reg <= res_addr_reg;
            m_status_reg  <= res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_address = m_address_reg;
    assign m_status  = m_status_reg;

    always_comb begin
        stat               = '0;
        stat.func_free     = func_reg;
        stat.zero_size     = (n_reg == '0);
        stat.alloc_too_big = (n_reg > BW'(cpba_pkg::MAP_PAGES));
        stat.free_bad      = diff_reg[AW] ||
                             (start_full > AW'(cpba_pkg::MAP_PAGES)) ||
                             (free_end > (BW+1)'(cpba_pkg::MAP_PAGES));
        stat.scan_hit      = hit;
        stat.scan_last     = (word_reg == IW'(cpba_pkg::MAP_WORDS - 1));
        stat.upd_last      = (word_reg == hi_word);
        stat.out_free      = !m_valid_reg || m_ready;
    end

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending item");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (word_reg >= lo_word && word_reg <= hi_word))
        else $error("map write outside the page range");

    a_range_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd_start |-> (hi_reg >= lo_reg))
        else $error("page range inverted");

    a_run_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_addr |-> ((RW'(end_reg) + RW'(1)) >= RW'(n_reg)))
        else $error("found run shorter than the request");

endmodule

`default_nettype wire

// ===== design/contiguous_page_bitmap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator_core
// First-fit contiguous page allocator over a one-bit-per-page occupancy map.
// ----------------------------------------------------------------------------
// Flow: a rejected request goes from the range check to the result. A free
//   updates the map words its pages touch (8 pages per word). An allocate first
//   scans up to 64 map words, one word per cycle, then updates the run's words.
// Throughput: one item at a time; the next item is taken the cycle after the
//   result enters the output register, which holds it until taken.
// Reset: synchronous active low; every page reads free, config and state to defaults.
`default_nettype none

module contiguous_page_bitmap_allocator_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [cpba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cpba_pkg::ADDR_W-1:0]    cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_func,
    input  wire logic [cpba_pkg::BYTES_W-1:0]   s_byte_count,
    input  wire logic [cpba_pkg::ADDR_W-1:0]    s_virtual_address,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [cpba_pkg::ADDR_W-1:0]         m_address,
    output logic [1:0]                          m_status
);

    cpba_pkg::dp_cmd_t  cmd;
    cpba_pkg::dp_stat_t stat;

    cpba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cpba_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_func            (s_func),
        .s_byte_count      (s_byte_count),
        .s_virtual_address (s_virtual_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_address         (m_address),
        .m_status          (m_status),
        .cmd               (cmd),
        .stat              (stat)
    );

endmodule

`default_nettype wire
